@@ rtl/core/dlps_pkg.sv @@
// ----------------------------------------------------------------------------
// dlps_pkg - shared definitions for the delay line pitch shifter
// Default sizes, register codes, sequencer states and the half Welch window.
// ----------------------------------------------------------------------------
`default_nettype none

package dlps_pkg;

	localparam int BUFFER_DEPTH_DEF  = 16384;
	localparam int WINDOW_POINTS_DEF = 512;
	localparam int SAMPLE_BITS_DEF   = 24;

	localparam int PHASE_BITS     = 24;
	localparam int SPAN_BITS      = 14;
	localparam int WIN_BITS       = 16;
	localparam int CFG_DATA_BITS  = 24;
	localparam int CFG_INDEX_BITS = 2;
	localparam int WELCH_POINTS   = 256;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_INC   = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_SPAN = 2'd1;

	localparam logic [SPAN_BITS-1:0] SPAN_RESET = 14'd4176;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_D,
		ST_RD0,
		ST_RD1,
		ST_MUL_I,
		ST_MUL_W,
		ST_WGT,
		ST_MUL_O,
		ST_ACC,
		ST_FIN
	} dlps_state_t;

	// half Welch window in millionths
	localparam int unsigned HALF_WELCH_MICRO [WELCH_POINTS] = '{
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
		0, 6989, 14008, 21027, 28046, 35034, 42053, 49042,
		56061, 63049, 70038, 77057, 84045, 91034, 97992, 104980,
		111938, 118927, 125885, 132812, 139771, 146698, 153656, 160583,
		167480, 174408, 181305, 188202, 195068, 201935, 208801, 215668,
		222504, 229340, 236145, 242950, 249756, 256531, 263306, 270081,
		276825, 283539, 290253, 296967, 303650, 310333, 316986, 323639,
		330261, 336853, 343445, 350037, 356598, 363129, 369659, 376160,
		382660, 389130, 395569, 402008, 408417, 414795, 421173, 427521,
		433868, 440155, 446442, 452698, 458954, 465179, 471375, 477539,
		483704, 489807, 495911, 501984, 508057, 514069, 520081, 526062,
		532013, 537933, 543823, 549683, 555542, 561340, 567139, 572906,
		578644, 584351, 590027, 595673, 601288, 606873, 612427, 617950,
		623444, 628937, 634369, 639771, 645142, 650482, 655792, 661072,
		666321, 671509, 676697, 681854, 686951, 692047, 697083, 702087,
		707062, 712006, 716919, 721802, 726624, 731415, 736176, 740906,
		745605, 750244, 754883, 759460, 764008, 768494, 772980, 777405,
		781799, 786133, 790466, 794739, 798981, 803162, 807312, 811432,
		815521, 819550, 823547, 827515, 831421, 835297, 839142, 842926,
		846680, 850403, 854065, 857697, 861267, 864807, 868317, 871765,
		875183, 878540, 881866, 885162, 888397, 891602, 894745, 897858,
		900940, 903961, 906921, 909851, 912750, 915588, 918365, 921143,
		923828, 926483, 929108, 931671, 934204, 936676, 939117, 941498,
		943848, 946136, 948364, 950592, 952728, 954834, 956909, 958893,
		960876, 962799, 964661, 966492, 968262, 970001, 971680, 973297,
		974884, 976410, 977905, 979340, 980743, 982086, 983368, 984619,
		985840, 986969, 988068, 989136, 990143, 991089, 992004, 992859,
		993652, 994415, 995148, 995789, 996429, 996979, 997498, 997955,
		998383, 998749, 999084, 999329, 999573, 999725, 999847, 999939,
		999969, 999969, 999969, 999969, 999969, 999969, 999969, 999969,
		999969, 999969, 999969, 999969, 999969, 999969, 999969, 999969
	};

	// millionths to Q1.15, round half up; only called on constants
	function automatic logic [WIN_BITS-1:0] welch_q15(int unsigned micro);
		logic [63:0] scaled;
		scaled = 64'(micro) * 64'd32768 + 64'd500000;
		return WIN_BITS'(scaled / 64'd1000000);
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/dlps_if.sv @@
// ----------------------------------------------------------------------------
// dlps_if - sample channels of the delay line pitch shifter
// Valid/ready channels carrying one signed audio sample per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface dlps_feed_if #(
	parameter int SAMPLE_BITS = dlps_pkg::SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface dlps_result_if #(
	parameter int SAMPLE_BITS = dlps_pkg::SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

@@ rtl/core/delay_line_pitch_shifter_core.sv @@
// ----------------------------------------------------------------------------
// delay_line_pitch_shifter_core - two-read overlap delay pitch shifter
// Each sample enters a circular delay store; two windowed, interpolated reads
// half a sweep apart are summed and saturated into one output sample.
// ----------------------------------------------------------------------------
// Usage:
//   feed   : one signed sample per transfer (valid & ready).
//   result : one pitch-shifted sample per input transfer, same order.
//   cfg    : cfg_we/cfg_index/cfg_data write the phase step (index 0) and the
//            window span in samples (index 1); write only while idle.
// Timing:
//   An item passes through the transfer step, 8 sequencer steps per read
//   position (two positions), and one finish step. The step count is set by
//   the single shared multiplier (eight products per item) and the one read
//   port of the store. The result is registered out of the finish step.
// Stall:
//   The finished sample sits in an output register. A new input is taken while
//   it waits; the next result holds in the finish step until that register
//   is free.
// Reset:
//   Phase, write pointer and fill count clear, registers take their defaults.
//   A fill count tracks which store entries were written, so unwritten entries
//   read as zero; no clearing pass is run and the block is ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module delay_line_pitch_shifter_core #(
	parameter int BUFFER_DEPTH  = dlps_pkg::BUFFER_DEPTH_DEF,
	parameter int WINDOW_POINTS = dlps_pkg::WINDOW_POINTS_DEF,
	parameter int SAMPLE_BITS   = dlps_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [dlps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [dlps_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	dlps_feed_if.sink                                  feed,
	dlps_result_if.source                              result
);

	localparam int PB = dlps_pkg::PHASE_BITS;
	localparam int SPB = dlps_pkg::SPAN_BITS;
	localparam int WBT = dlps_pkg::WIN_BITS;
	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int WB = $clog2(WINDOW_POINTS);   // window index bits
	localparam int HB = WB - 1;                   // half window index bits
	localparam int GB = PB - WB;                  // window fraction bits
	localparam int SB = SAMPLE_BITS;
	localparam int MA = (SB + 2 > WBT + 1) ? SB + 2 : WBT + 1;
	localparam int MB = PB + 1;
	localparam int PW = MA + MB;
	localparam int AB = SB + WBT + 1;
	localparam int YB = AB - 15;

	localparam logic signed [PW-1:0] HALF_LSB24 = PW'(24'h800000);
	localparam logic signed [AB-1:0] HALF_LSB15 = AB'(15'h4000);
	localparam logic signed [YB-1:0] Y_MAX = YB'((64'd1 << (SB - 1)) - 64'd1);
	localparam logic signed [YB-1:0] Y_MIN = -Y_MAX - YB'(1);
	localparam logic [PB-1:0] HALF_CYCLE = 24'h800000;

	// window source index: mirror, then scale onto the 256-point half table
	function automatic logic [7:0] win_src(logic [WB-1:0] j);
		logic [HB-1:0] i;
		logic [31:0]   w;
		i = j[WB-1] ? ~j[HB-1:0] : j[HB-1:0];
		w = 32'(i) << 8;
		return 8'(w >> HB);
	endfunction

	dlps_pkg::dlps_state_t state_q, state_d;

	// configuration and sweep state
	logic [PB-1:0]  inc_q;
	logic [SPB-1:0] span_q;
	logic [PB-1:0]  phase_q;
	logic [AW-1:0]  wp_q;
	logic [AW:0]    fill_q;
	logic           pos_sel_q;

	// datapath registers
	logic [PB-1:0]            ph_q;
	logic signed [PW-1:0]     prod_q;
	logic [AW-1:0]            i0_q;
	logic [PB-1:0]            f_q;
	logic signed [SB-1:0]     s0_q;
	logic signed [SB-1:0]     s1_q;
	logic [WBT-1:0]           wk_q;
	logic signed [WBT:0]      wd_q;
	logic signed [SB-1:0]     t_q;
	logic [WBT-1:0]           w_q;
	logic signed [AB-1:0]     acc_q;
	logic signed [SB-1:0]     out_q;
	logic                     out_valid_q;

	// delay store
	logic signed [SB-1:0] mem [BUFFER_DEPTH];
	logic signed [SB-1:0] rd_q;
	logic                 rd_ok_q;

	logic [WBT-1:0] welch_rom [dlps_pkg::WELCH_POINTS];

	logic                 accept;
	logic                 load_out;
	logic                 mem_we;
	logic [AW-1:0]        rd_addr;
	logic                 rd_ok;
	logic [AW-1:0]        i0;
	logic signed [SB-1:0] rd_val;
	logic signed [MA-1:0] mul_a;
	logic signed [MB-1:0] mul_b;
	logic signed [PW-1:0] rnd24;
	logic signed [PW-25:0] corr;
	logic signed [SB:0]   sdiff;
	logic [WB-1:0]        wk;
	logic [WB-1:0]        wk2;
	logic [WBT-1:0]       win0;
	logic [WBT-1:0]       win1;
	logic [PB-1:0]        g;
	logic signed [AB-1:0] rnd15;
	logic signed [YB-1:0] y;
	logic signed [SB-1:0] y_sat;

	for (genvar gi = 0; gi < dlps_pkg::WELCH_POINTS; gi++) begin : g_rom
		assign welch_rom[gi] = dlps_pkg::welch_q15(dlps_pkg::HALF_WELCH_MICRO[gi]);
	end

	// unwritten entries read as zero
	assign rd_val = rd_ok_q ? rd_q : '0;
	assign i0     = wp_q - AW'(prod_q[PB +: SPB]);
	assign rd_ok  = fill_q[AW] || ({1'b0, rd_addr} < fill_q);

	// round-half-up drop of 24 fraction bits from the product
	assign rnd24 = prod_q + HALF_LSB24;
	assign corr  = rnd24[PW-1:24];

	assign sdiff = (SB + 1)'(s0_q) - (SB + 1)'(rd_val);
	assign wk    = ph_q[PB-1 -: WB];
	assign wk2   = wk + WB'(1);
	assign win0  = welch_rom[win_src(wk)];
	assign win1  = welch_rom[win_src(wk2)];
	assign g     = {ph_q[GB-1:0], {WB{1'b0}}};

	assign rnd15 = acc_q + HALF_LSB15;
	assign y     = rnd15[AB-1:15];

	always_comb begin
		if (y > Y_MAX) begin
			y_sat = SB'(Y_MAX);
		end else if (y < Y_MIN) begin
			y_sat = SB'(Y_MIN);
		end else begin
			y_sat = SB'(y);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dlps_pkg::ST_IDLE: begin
				if (feed.valid) state_d = dlps_pkg::ST_MUL_D;
			end
			dlps_pkg::ST_MUL_D: state_d = dlps_pkg::ST_RD0;
			dlps_pkg::ST_RD0:   state_d = dlps_pkg::ST_RD1;
			dlps_pkg::ST_RD1:   state_d = dlps_pkg::ST_MUL_I;
			dlps_pkg::ST_MUL_I: state_d = dlps_pkg::ST_MUL_W;
			dlps_pkg::ST_MUL_W: state_d = dlps_pkg::ST_WGT;
			dlps_pkg::ST_WGT:   state_d = dlps_pkg::ST_MUL_O;
			dlps_pkg::ST_MUL_O: state_d = dlps_pkg::ST_ACC;
			dlps_pkg::ST_ACC: begin
				state_d = pos_sel_q ? dlps_pkg::ST_FIN : dlps_pkg::ST_MUL_D;
			end
			dlps_pkg::ST_FIN: begin
				if (!out_valid_q || result.ready) state_d = dlps_pkg::ST_IDLE;
			end
			default: state_d = dlps_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake, store port, shared multiplier operands
	always_comb begin
		feed.ready = 1'b0;
		load_out   = 1'b0;
		rd_addr    = i0;
		mul_a      = '0;
		mul_b      = '0;
		case (state_q)
			dlps_pkg::ST_IDLE: feed.ready = 1'b1;
			dlps_pkg::ST_MUL_D: begin
				mul_a = MA'($signed({1'b0, span_q}));
				mul_b = $signed({1'b0, ph_q});
			end
			dlps_pkg::ST_RD0: rd_addr = i0;
			dlps_pkg::ST_RD1: rd_addr = i0_q + AW'(1);
			dlps_pkg::ST_MUL_I: begin
				mul_a = MA'(sdiff);
				mul_b = $signed({1'b0, f_q});
			end
			dlps_pkg::ST_MUL_W: begin
				mul_a = MA'(wd_q);
				mul_b = $signed({1'b0, g});
			end
			dlps_pkg::ST_WGT: ;
			dlps_pkg::ST_MUL_O: begin
				mul_a = MA'(t_q);
				mul_b = $signed({(MB - WBT)'(0), w_q});
			end
			dlps_pkg::ST_ACC: ;
			dlps_pkg::ST_FIN: load_out = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	assign accept = feed.valid && feed.ready;
	assign mem_we = accept;

	assign result.valid      = out_valid_q;
	assign result.sample_out = out_q;

	// delay store: one write port and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[wp_q] <= SB'(feed.sample_in);
		rd_q <= mem[rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dlps_pkg::ST_IDLE;
			inc_q       <= '0;
			span_q      <= dlps_pkg::SPAN_RESET;
			phase_q     <= '0;
			wp_q        <= '0;
			fill_q      <= '0;
			pos_sel_q   <= 1'b0;
			out_valid_q <= 1'b0;
			rd_ok_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_ok_q <= rd_ok;
			if (cfg_we) begin
				case (cfg_index)
					dlps_pkg::CFG_PHASE_INC:   inc_q  <= cfg_data[PB-1:0];
					dlps_pkg::CFG_WINDOW_SPAN: span_q <= cfg_data[SPB-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				pos_sel_q <= 1'b0;
				if (!fill_q[AW]) fill_q <= fill_q + (AW + 1)'(1);
			end
			if (state_q == dlps_pkg::ST_ACC) pos_sel_q <= 1'b1;
			if (load_out) begin
				out_valid_q <= 1'b1;
				wp_q        <= wp_q + AW'(1);
				phase_q     <= phase_q + inc_q;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			dlps_pkg::ST_IDLE: begin
				ph_q  <= phase_q;
				acc_q <= '0;
			end
			dlps_pkg::ST_MUL_D: prod_q <= mul_a * mul_b;
			dlps_pkg::ST_RD0: begin
				i0_q <= i0;
				f_q  <= prod_q[PB-1:0];
			end
			dlps_pkg::ST_RD1: s0_q <= rd_val;
			dlps_pkg::ST_MUL_I: begin
				s1_q   <= rd_val;
				prod_q <= mul_a * mul_b;
				wk_q   <= win0;
				wd_q   <= $signed({1'b0, win1}) - $signed({1'b0, win0});
			end
			dlps_pkg::ST_MUL_W: begin
				t_q    <= s1_q + SB'(corr);
				prod_q <= mul_a * mul_b;
			end
			dlps_pkg::ST_WGT: w_q <= wk_q + WBT'(corr);
			dlps_pkg::ST_MUL_O: prod_q <= mul_a * mul_b;
			dlps_pkg::ST_ACC: begin
				acc_q <= acc_q + AB'(prod_q);
				ph_q  <= ph_q + HALF_CYCLE;
			end
			dlps_pkg::ST_FIN: begin
				if (load_out) out_q <= y_sat;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/dlps_checker.sv @@
// ----------------------------------------------------------------------------
// dlps_checker - port-level checks for the pitch shifter core
// Watches both sample channels; bound to the core below.
// ----------------------------------------------------------------------------
`default_nettype none

module dlps_checker #(
	parameter int SAMPLE_BITS = dlps_pkg::SAMPLE_BITS_DEF
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic signed [SAMPLE_BITS-1:0] out_data
);

	// one item in flight: a transfer makes the core busy
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in flight");

	// a result only appears out of the finish step, never straight from idle
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a busy finish step");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed or dropped");

endmodule

bind delay_line_pitch_shifter_core dlps_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_dlps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (feed.valid),
	.in_ready  (feed.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.sample_out)
);

`default_nettype wire
